// ----- design/vfsp_pkg.sv -----
package vfsp_pkg;

  localparam logic [2:0] EV_VOXEL        = 3'd0;
  localparam logic [2:0] EV_DIMENSIONS   = 3'd1;
  localparam logic [2:0] EV_HEADER_OK    = 3'd2;
  localparam logic [2:0] EV_BAD_HEADER   = 3'd3;
  localparam logic [2:0] EV_SIZE_MISSING = 3'd4;
  localparam logic [2:0] EV_XYZI_MISSING = 3'd5;
  localparam logic [2:0] EV_MAIN_MISSING = 3'd6;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         voxel_x;
    logic [7:0]         voxel_y;
    logic [7:0]         voxel_z;
    logic [7:0]         material;
    logic signed [31:0] size_x;
    logic signed [31:0] size_y;
    logic signed [31:0] size_z;
    logic signed [31:0] file_version;
    logic [30:0]        model_number;
    logic               last_voxel;
  } event_t;

endpackage

// ----- design/voxel_file_stream_parser.sv -----
// Voxel file stream parser.
// The data channel (data_valid, data_stall, data_byte, start_of_file) takes
// one byte of the file per request, in file order. A request with
// start_of_file high restarts parsing at that byte, which is read as the
// first magic byte.
// The event channel (event_valid, event_stall and the event fields) gives at
// most one event per byte: a voxel, a set of model dimensions, the header
// result or an error. Fields that do not belong to an event read as zero.
// A byte accepted into the input register is parsed from there, and its event
// is registered onto the ports. One byte is taken every cycle while the
// receiver keeps up; a byte needs a single pass through the parse logic.
// When the receiver stalls, a second event is held in a skid register and
// data_stall rises only once that register is full, so no event is lost.
// Reset clears the parse state to the start of a file and empties both
// channels; it is synchronous.
module voxel_file_stream_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               data_valid,
  output logic               data_stall,
  input  logic [7:0]         data_byte,
  input  logic               start_of_file,
  output logic               event_valid,
  input  logic               event_stall,
  output logic [2:0]         event_kind,
  output logic [7:0]         voxel_x,
  output logic [7:0]         voxel_y,
  output logic [7:0]         voxel_z,
  output logic [7:0]         material,
  output logic signed [31:0] size_x,
  output logic signed [31:0] size_y,
  output logic signed [31:0] size_z,
  output logic signed [31:0] file_version,
  output logic [30:0]        model_number,
  output logic               last_voxel
);
  import vfsp_pkg::*;

  logic       in_full;
  logic [7:0] in_byte;
  logic       in_sof;
  logic       step;
  event_t     res;
  logic       res_valid;
  event_t     held;
  logic       skid_valid;
  event_t     skid;

  assign data_stall = in_full && skid_valid;
  assign step       = in_full && !skid_valid;

  vfsp_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .data_byte     (in_byte),
    .start_of_file (in_sof),
    .res           (res),
    .res_valid     (res_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (data_valid && !data_stall) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
    if (data_valid && !data_stall) begin
      in_byte <= data_byte;
      in_sof  <= start_of_file;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (step && res_valid) begin
      if (event_valid && event_stall) begin
        skid       <= res;
        skid_valid <= 1'b1;
      end else begin
        held        <= res;
        event_valid <= 1'b1;
      end
    end else if (event_valid && !event_stall) begin
      if (skid_valid) begin
        held       <= skid;
        skid_valid <= 1'b0;
      end else begin
        event_valid <= 1'b0;
      end
    end
  end

  assign event_kind   = held.kind;
  assign voxel_x      = held.voxel_x;
  assign voxel_y      = held.voxel_y;
  assign voxel_z      = held.voxel_z;
  assign material     = held.material;
  assign size_x       = held.size_x;
  assign size_y       = held.size_y;
  assign size_z       = held.size_z;
  assign file_version = held.file_version;
  assign model_number = held.model_number;
  assign last_voxel   = held.last_voxel;

`ifndef NO_ASSERTIONS
  a_skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> event_valid)
    else $error("Skid register holds an event while the output is empty.");
  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(event_valid && event_stall))
    else $error("Skid register filled without a stalled output.");
`endif

endmodule

// ----- design/vfsp_core.sv -----
module vfsp_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      data_byte,
  input  logic            start_of_file,
  output vfsp_pkg::event_t res,
  output logic            res_valid
);
  import vfsp_pkg::*;

  typedef enum logic [3:0] {
    PH_MAGIC, PH_VERSION, PH_MAIN_HDR, PH_SECOND_HDR, PH_PACK_COUNT, PH_TOP_DIMS,
    PH_SIZE_HDR, PH_DIMS, PH_XYZI_HDR, PH_VOX_COUNT, PH_VOXELS, PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    CK_MAIN = 3'd0, CK_PACK = 3'd1, CK_SIZE = 3'd2, CK_XYZI = 3'd3, CK_RGBA = 3'd4,
    CK_UNKNOWN = 3'd7
  } chunk_t;

  localparam logic [7:0] CHAR_M     = 8'h4d;
  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_S     = 8'h53;
  localparam logic [7:0] CHAR_X     = 8'h58;
  localparam logic [7:0] CHAR_R     = 8'h52;
  localparam logic [7:0] CHAR_V     = 8'h56;
  localparam logic [7:0] CHAR_O     = 8'h4f;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  phase_t      phase, phase_next, ph_c;
  logic [3:0]  pos, pos_next, pos_c, pos_inc;
  logic [31:0] word, word_next, word_c;
  chunk_t      ck, ck_next, ck_c, kind_b;
  logic [31:0] d0, d0_next, d0_c;
  logic [31:0] d1, d1_next, d1_c;
  logic [30:0] ml, ml_next, ml_c, ml_dec;
  logic [30:0] mc, mc_next, mc_c, mc_inc;
  logic [30:0] vl, vl_next, vl_c;
  logic [30:0] count_w;
  logic [7:0]  ub, magic_ch;
  logic        neg;

  function automatic phase_t entry_phase(input logic [30:0] left, input chunk_t kind);
    phase_t p;
    if (left == '0) begin
      p = PH_DONE;
    end else if (kind == CK_SIZE) begin
      p = PH_XYZI_HDR;
    end else begin
      p = PH_SIZE_HDR;
    end
    return p;
  endfunction

  always_comb begin
    ub = (data_byte >= 8'h61 && data_byte <= 8'h7a) ? data_byte - 8'd32 : data_byte;
    case (ub)
      CHAR_M:  kind_b = CK_MAIN;
      CHAR_P:  kind_b = CK_PACK;
      CHAR_S:  kind_b = CK_SIZE;
      CHAR_X:  kind_b = CK_XYZI;
      CHAR_R:  kind_b = CK_RGBA;
      default: kind_b = CK_UNKNOWN;
    endcase
  end

  always_comb begin
    ph_c   = start_of_file ? PH_MAGIC : phase;
    pos_c  = start_of_file ? 4'd0 : pos;
    word_c = start_of_file ? 32'd0 : word;
    ck_c   = start_of_file ? CK_UNKNOWN : ck;
    d0_c   = start_of_file ? 32'd0 : d0;
    d1_c   = start_of_file ? 32'd0 : d1;
    ml_c   = start_of_file ? 31'd1 : ml;
    mc_c   = start_of_file ? 31'd0 : mc;
    vl_c   = start_of_file ? 31'd0 : vl;

    case (pos_c[1:0])
      2'd0:    magic_ch = CHAR_V;
      2'd1:    magic_ch = CHAR_O;
      2'd2:    magic_ch = CHAR_X;
      default: magic_ch = CHAR_SPACE;
    endcase

    word_next = {data_byte, word_c[31:8]};
    neg       = data_byte[7];
    count_w   = neg ? 31'd0 : word_next[30:0];
    ml_dec    = ml_c - 31'd1;
    mc_inc    = mc_c + 31'd1;
    pos_inc   = pos_c + 4'd1;

    phase_next = ph_c;
    pos_next   = pos_c;
    ck_next    = ck_c;
    d0_next    = d0_c;
    d1_next    = d1_c;
    ml_next    = ml_c;
    mc_next    = mc_c;
    vl_next    = vl_c;
    res        = '0;
    res_valid  = 1'b0;

    case (ph_c)
      PH_MAGIC: begin
        if (ub != magic_ch) begin
          phase_next       = PH_DONE;
          res.kind         = EV_BAD_HEADER;
          res.file_version = '1;
          res_valid        = 1'b1;
        end else if (pos_c >= 4'd3) begin
          phase_next = PH_VERSION;
          pos_next   = 4'd0;
        end else begin
          pos_next = pos_inc;
        end
      end
      PH_VERSION, PH_PACK_COUNT, PH_VOX_COUNT: begin
        if (pos_c < 4'd3) begin
          pos_next = pos_inc;
        end else begin
          pos_next = 4'd0;
          if (ph_c == PH_VERSION) begin
            res.kind         = neg ? EV_BAD_HEADER : EV_HEADER_OK;
            res.file_version = word_next;
            res_valid        = 1'b1;
            phase_next       = neg ? PH_DONE : PH_MAIN_HDR;
          end else if (ph_c == PH_PACK_COUNT) begin
            ml_next    = count_w;
            phase_next = entry_phase(count_w, ck_c);
          end else begin
            vl_next = count_w;
            if (count_w == '0) begin
              ml_next    = ml_dec;
              mc_next    = mc_inc;
              phase_next = entry_phase(ml_dec, ck_c);
            end else begin
              phase_next = PH_VOXELS;
            end
          end
        end
      end
      PH_MAIN_HDR, PH_SECOND_HDR, PH_SIZE_HDR, PH_XYZI_HDR: begin
        if (pos_c == 4'd0) begin
          ck_next = kind_b;
        end
        if (pos_c < 4'd11) begin
          pos_next = pos_inc;
        end else begin
          pos_next = 4'd0;
          if (ph_c == PH_MAIN_HDR) begin
            if (ck_c != CK_MAIN) begin
              phase_next = PH_DONE;
              res.kind   = EV_MAIN_MISSING;
              res_valid  = 1'b1;
            end else begin
              phase_next = PH_SECOND_HDR;
            end
          end else if (ph_c == PH_SECOND_HDR) begin
            if (ck_c == CK_PACK) begin
              phase_next = PH_PACK_COUNT;
            end else if (ck_c == CK_SIZE) begin
              phase_next = PH_TOP_DIMS;
            end else begin
              phase_next = entry_phase(ml_c, ck_c);
            end
          end else if (ph_c == PH_SIZE_HDR) begin
            if (ck_c == CK_SIZE) begin
              phase_next = PH_DIMS;
            end else begin
              phase_next       = PH_XYZI_HDR;
              res.kind         = EV_SIZE_MISSING;
              res.model_number = mc_c;
              res_valid        = 1'b1;
            end
          end else begin
            if (ck_c == CK_XYZI) begin
              phase_next = PH_VOX_COUNT;
            end else begin
              res.kind         = EV_XYZI_MISSING;
              res.model_number = mc_c;
              res_valid        = 1'b1;
              ml_next          = ml_dec;
              mc_next          = mc_inc;
              phase_next       = entry_phase(ml_dec, ck_c);
            end
          end
        end
      end
      PH_TOP_DIMS, PH_DIMS: begin
        if (pos_c == 4'd3) begin
          d0_next = word_next;
        end else if (pos_c == 4'd7) begin
          d1_next = word_next;
        end
        if (pos_c < 4'd11) begin
          pos_next = pos_inc;
        end else begin
          pos_next         = 4'd0;
          res.kind         = EV_DIMENSIONS;
          res.size_x       = d0_c;
          res.size_y       = d1_c;
          res.size_z       = word_next;
          res.model_number = mc_c;
          res_valid        = 1'b1;
          phase_next       = (ph_c == PH_TOP_DIMS) ? entry_phase(ml_c, ck_c) : PH_XYZI_HDR;
        end
      end
      PH_VOXELS: begin
        if (pos_c < 4'd3) begin
          pos_next = pos_inc;
        end else begin
          pos_next         = 4'd0;
          vl_next          = vl_c - 31'd1;
          res.kind         = EV_VOXEL;
          res.voxel_x      = word_next[7:0];
          res.voxel_y      = word_next[15:8];
          res.voxel_z      = word_next[23:16];
          res.material     = data_byte;
          res.model_number = mc_c;
          res.last_voxel   = (vl_c == 31'd1);
          res_valid        = 1'b1;
          if (vl_c == 31'd1) begin
            ml_next    = ml_dec;
            mc_next    = mc_inc;
            phase_next = entry_phase(ml_dec, ck_c);
          end
        end
      end
      default: begin
        phase_next = PH_DONE;
        pos_next   = 4'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_MAGIC;
      pos   <= 4'd0;
      word  <= 32'd0;
      ck    <= CK_UNKNOWN;
      d0    <= 32'd0;
      d1    <= 32'd0;
      ml    <= 31'd1;
      mc    <= 31'd0;
      vl    <= 31'd0;
    end else if (step) begin
      phase <= phase_next;
      pos   <= pos_next;
      word  <= word_next;
      ck    <= ck_next;
      d0    <= d0_next;
      d1    <= d1_next;
      ml    <= ml_next;
      mc    <= mc_next;
      vl    <= vl_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_pos_range: assert property (@(posedge clk) disable iff (rst) pos <= 4'd11)
    else $error("Byte position left the header range.");
  a_voxel_realign: assert property (@(posedge clk) disable iff (rst)
    step && res_valid && res.kind == EV_VOXEL |=> pos == 4'd0)
    else $error("Byte position not cleared after a voxel.");
`endif

endmodule

// ----- tb/voxel_file_stream_parser_tb.sv -----
`timescale 1ns / 1ps

module voxel_file_stream_parser_tb;

  import vfsp_pkg::*;

  localparam int LONG_HOLD    = 40;
  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_BYTES = 240;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [31:0] MAGIC_WORD = "VOX ";

  typedef enum logic [3:0] {
    AT_MAGIC, AT_VERSION, AT_MAIN, AT_SECOND, AT_PACK_COUNT, AT_TOP_DIMS,
    AT_SIZE, AT_DIMS, AT_XYZI, AT_VOX_COUNT, AT_VOXELS, AT_DONE
  } parse_phase_e;

  typedef enum logic [2:0] {
    CH_MAIN = 3'd0, CH_PACK = 3'd1, CH_SIZE = 3'd2, CH_XYZI = 3'd3,
    CH_RGBA = 3'd4, CH_OTHER = 3'd7
  } chunk_e;

  typedef enum int {FLAW_NONE, FLAW_NO_SIZE, FLAW_NO_XYZI} flaw_e;

  logic               clk;
  logic               rst;
  logic               data_valid;
  logic               data_stall;
  logic [7:0]         data_byte;
  logic               start_of_file;
  logic               event_valid;
  logic               event_stall;
  logic [2:0]         event_kind;
  logic [7:0]         voxel_x;
  logic [7:0]         voxel_y;
  logic [7:0]         voxel_z;
  logic [7:0]         material;
  logic signed [31:0] size_x;
  logic signed [31:0] size_y;
  logic signed [31:0] size_z;
  logic signed [31:0] file_version;
  logic [30:0]        model_number;
  logic               last_voxel;

  parse_phase_e ps_phase;
  logic [3:0]   ps_pos;
  logic [31:0]  ps_word;
  chunk_e       ps_chunk;
  logic [31:0]  ps_dim_x;
  logic [31:0]  ps_dim_y;
  logic [31:0]  ps_models_left;
  logic [30:0]  ps_model_idx;
  logic [31:0]  ps_voxels_left;
  logic [23:0]  ps_voxel_xyz;

  event_t     expected_events[$];
  logic [7:0] file_q[$];
  int         errors = 0;
  int         bytes_sent = 0;
  int         kind_seen[8];
  int         quiet_cycles = 0;
  bit         idle_on = 1'b1;
  bit         hold_request = 1'b0;

  voxel_file_stream_parser dut (
    .clk(clk),
    .rst(rst),
    .data_valid(data_valid),
    .data_stall(data_stall),
    .data_byte(data_byte),
    .start_of_file(start_of_file),
    .event_valid(event_valid),
    .event_stall(event_stall),
    .event_kind(event_kind),
    .voxel_x(voxel_x),
    .voxel_y(voxel_y),
    .voxel_z(voxel_z),
    .material(material),
    .size_x(size_x),
    .size_y(size_y),
    .size_z(size_z),
    .file_version(file_version),
    .model_number(model_number),
    .last_voxel(last_voxel)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] upcase(input logic [7:0] c);
    if (c >= "a" && c <= "z") return c - 8'd32;
    return c;
  endfunction

  function automatic chunk_e chunk_of(input logic [7:0] c);
    case (upcase(c))
      "M": return CH_MAIN;
      "P": return CH_PACK;
      "S": return CH_SIZE;
      "X": return CH_XYZI;
      "R": return CH_RGBA;
      default: return CH_OTHER;
    endcase
  endfunction

  task automatic clear_parse_state();
    ps_phase = AT_MAGIC;
    ps_pos = '0;
    ps_word = '0;
    ps_chunk = CH_OTHER;
    ps_dim_x = '0;
    ps_dim_y = '0;
    ps_models_left = 32'd1;
    ps_model_idx = '0;
    ps_voxels_left = '0;
    ps_voxel_xyz = '0;
  endtask

  task automatic enter_model();
    if (ps_models_left == 0) ps_phase = AT_DONE;
    else if (ps_chunk == CH_SIZE) ps_phase = AT_XYZI;
    else ps_phase = AT_SIZE;
    ps_pos = '0;
  endtask

  task automatic finish_model();
    ps_models_left = ps_models_left - 1;
    ps_model_idx = ps_model_idx + 1;
    enter_model();
  endtask

  task automatic predict_parse_event(input logic [7:0] b, input logic sof,
                                     output bit produced, output event_t ev);
    logic [3:0] pos;
    bit         neg;
    produced = 1'b0;
    ev = '0;
    if (sof) clear_parse_state();
    pos = ps_pos;
    ps_word = {b, ps_word[31:8]};
    neg = ps_word[31];
    case (ps_phase)
      AT_MAGIC: begin
        if (upcase(b) != MAGIC_WORD[31 - 8 * pos[1:0] -: 8]) begin
          ps_phase = AT_DONE;
          produced = 1'b1;
          ev.kind = EV_BAD_HEADER;
          ev.file_version = 32'hFFFF_FFFF;
        end else if (pos >= 3) begin
          ps_phase = AT_VERSION;
          ps_pos = '0;
        end else begin
          ps_pos = pos + 1;
        end
      end
      AT_VERSION, AT_PACK_COUNT, AT_VOX_COUNT: begin
        if (pos < 3) begin
          ps_pos = pos + 1;
        end else begin
          ps_pos = '0;
          if (ps_phase == AT_VERSION) begin
            produced = 1'b1;
            ev.file_version = ps_word;
            if (neg) begin
              ev.kind = EV_BAD_HEADER;
              ps_phase = AT_DONE;
            end else begin
              ev.kind = EV_HEADER_OK;
              ps_phase = AT_MAIN;
            end
          end else if (ps_phase == AT_PACK_COUNT) begin
            ps_models_left = neg ? 32'd0 : ps_word;
            enter_model();
          end else begin
            ps_voxels_left = neg ? 32'd0 : ps_word;
            if (ps_voxels_left == 0) finish_model();
            else ps_phase = AT_VOXELS;
          end
        end
      end
      AT_MAIN, AT_SECOND, AT_SIZE, AT_XYZI: begin
        if (pos == 0) ps_chunk = chunk_of(b);
        if (pos < 11) begin
          ps_pos = pos + 1;
        end else begin
          ps_pos = '0;
          case (ps_phase)
            AT_MAIN: begin
              if (ps_chunk != CH_MAIN) begin
                ps_phase = AT_DONE;
                produced = 1'b1;
                ev.kind = EV_MAIN_MISSING;
              end else begin
                ps_phase = AT_SECOND;
              end
            end
            AT_SECOND: begin
              if (ps_chunk == CH_PACK) ps_phase = AT_PACK_COUNT;
              else if (ps_chunk == CH_SIZE) ps_phase = AT_TOP_DIMS;
              else enter_model();
            end
            AT_SIZE: begin
              if (ps_chunk == CH_SIZE) begin
                ps_phase = AT_DIMS;
              end else begin
                ps_phase = AT_XYZI;
                produced = 1'b1;
                ev.kind = EV_SIZE_MISSING;
                ev.model_number = ps_model_idx;
              end
            end
            default: begin
              if (ps_chunk == CH_XYZI) begin
                ps_phase = AT_VOX_COUNT;
              end else begin
                produced = 1'b1;
                ev.kind = EV_XYZI_MISSING;
                ev.model_number = ps_model_idx;
                finish_model();
              end
            end
          endcase
        end
      end
      AT_TOP_DIMS, AT_DIMS: begin
        if (pos == 3) ps_dim_x = ps_word;
        else if (pos == 7) ps_dim_y = ps_word;
        if (pos < 11) begin
          ps_pos = pos + 1;
        end else begin
          produced = 1'b1;
          ev.kind = EV_DIMENSIONS;
          ev.size_x = ps_dim_x;
          ev.size_y = ps_dim_y;
          ev.size_z = ps_word;
          ev.model_number = ps_model_idx;
          if (ps_phase == AT_TOP_DIMS) begin
            enter_model();
          end else begin
            ps_phase = AT_XYZI;
            ps_pos = '0;
          end
        end
      end
      AT_VOXELS: begin
        if (pos < 3) begin
          ps_voxel_xyz[pos * 8 +: 8] = b;
          ps_pos = pos + 1;
        end else begin
          ps_pos = '0;
          ps_voxels_left = ps_voxels_left - 1;
          produced = 1'b1;
          ev.kind = EV_VOXEL;
          ev.voxel_x = ps_voxel_xyz[7:0];
          ev.voxel_y = ps_voxel_xyz[15:8];
          ev.voxel_z = ps_voxel_xyz[23:16];
          ev.material = b;
          ev.model_number = ps_model_idx;
          ev.last_voxel = (ps_voxels_left == 0);
          if (ps_voxels_left == 0) finish_model();
        end
      end
      default: begin
        ps_phase = AT_DONE;
        ps_pos = '0;
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input logic sof);
    int     gap;
    bit     produced;
    event_t ev;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      data_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    data_valid <= 1'b1;
    data_byte <= b;
    start_of_file <= sof;
    do @(posedge clk); while (data_stall);
    predict_parse_event(b, sof, produced, ev);
    if (produced) expected_events.push_back(ev);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_file(input bit with_sof);
    foreach (file_q[i]) send_byte(file_q[i], with_sof && i == 0);
    file_q.delete();
  endtask

  function automatic logic [7:0] mixcase(input logic [7:0] c);
    if (c >= "A" && c <= "Z" && $urandom_range(0, 1)) return c ^ 8'h20;
    return c;
  endfunction

  task automatic add_text(input string s);
    foreach (s[i]) file_q.push_back(s[i]);
  endtask

  task automatic add_magic();
    string s;
    s = "VOX ";
    foreach (s[i]) file_q.push_back(mixcase(s[i]));
  endtask

  task automatic add_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) file_q.push_back(w[8 * i +: 8]);
  endtask

  task automatic add_bytes(input int n);
    repeat (n) file_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_hdr(input logic [7:0] letter);
    file_q.push_back(mixcase(letter));
    add_bytes(11);
  endtask

  task automatic add_model(input flaw_e flaw, input bit with_size, input logic [31:0] count);
    if (with_size) begin
      if (flaw == FLAW_NO_SIZE) begin
        add_hdr($urandom_range(0, 1) ? "R" : "X");
      end else begin
        add_hdr("S");
        repeat (3) add_word($urandom);
      end
    end
    if (flaw == FLAW_NO_XYZI) begin
      add_hdr($urandom_range(0, 1) ? "S" : "M");
    end else begin
      add_hdr("X");
      add_word(count);
      if (!count[31]) add_bytes(4 * count);
    end
  endtask

  function automatic logic [31:0] vox_count();
    if ($urandom_range(0, 14) == 0) return 32'hFFFF_FFFF - $urandom_range(0, 3);
    if ($urandom_range(0, 9) == 0) return 32'd0;
    return $urandom_range(1, 6);
  endfunction

  function automatic flaw_e pick_flaw();
    case ($urandom_range(0, 9))
      0: return FLAW_NO_SIZE;
      1: return FLAW_NO_XYZI;
      default: return FLAW_NONE;
    endcase
  endfunction

  task automatic test_file_header();
    add_text("vox ");
    add_word(32'd0);
    add_hdr("R");
    add_bytes(3);
    send_file(1'b0);
    add_text("Q");
    add_bytes(3);
    send_file(1'b1);
    add_text("VOx_");
    add_bytes(2);
    send_file(1'b1);
    add_text("VoX ");
    add_word(32'h8000_0000);
    add_bytes(12);
    send_file(1'b1);
    add_text("VOX ");
    add_word(32'hFFFF_FFFF);
    send_file(1'b1);
    add_text("VOX ");
    add_word(32'h7FFF_FFFF);
    add_hdr("m");
    add_hdr("p");
    add_word(32'd0);
    add_bytes(5);
    send_file(1'b1);
  endtask

  task automatic test_chunk_rules();
    add_text("VOX ");
    add_word(32'd150);
    add_hdr("M");
    add_hdr("P");
    add_word(32'd4);
    add_model(FLAW_NONE, 1'b1, 32'd2);
    add_model(FLAW_NO_SIZE, 1'b1, 32'd1);
    add_hdr("S");
    add_hdr("X");
    add_word(32'd1);
    add_bytes(4);
    add_bytes(6);
    send_file(1'b1);
    add_text("VOX ");
    add_word(32'd1);
    add_hdr("M");
    add_hdr("S");
    add_word(32'h7FFF_FFFF);
    add_word(32'h8000_0000);
    add_word(32'd0);
    add_hdr("X");
    add_word(32'd2);
    add_word(32'd0);
    add_word(32'hFFFF_FFFF);
    add_bytes(3);
    send_file(1'b1);
    add_text("VOX ");
    add_word(32'd2);
    add_hdr("M");
    add_hdr("R");
    add_model(FLAW_NONE, 1'b1, 32'hFFFF_FFFF);
    add_bytes(4);
    send_file(1'b1);
    add_text("VOX ");
    add_word(32'd3);
    add_hdr("M");
    add_hdr("S");
    repeat (3) add_word($urandom);
    add_model(FLAW_NONE, 1'b0, 32'd0);
    add_bytes(2);
    send_file(1'b1);
    add_text("VOX ");
    add_word(32'd4);
    add_hdr("M");
    add_hdr("P");
    add_word(32'h8000_0000);
    add_bytes(5);
    send_file(1'b1);
  endtask

  task automatic test_restart();
    add_text("VOX ");
    add_word(32'd5);
    add_hdr("M");
    add_hdr("S");
    repeat (3) add_word($urandom);
    add_hdr("X");
    add_word(32'd3);
    add_bytes(6);
    send_file(1'b1);
    add_text("VO");
    send_file(1'b1);
    add_text("VOX ");
    add_word(32'd6);
    add_hdr("M");
    add_hdr("S");
    repeat (3) add_word($urandom);
    add_model(FLAW_NONE, 1'b0, 32'd1);
    send_file(1'b1);
  endtask

  task automatic test_back_pressure();
    idle_on = 1'b0;
    add_magic();
    add_word(32'd7);
    add_hdr("M");
    add_hdr("S");
    repeat (3) add_word($urandom);
    add_hdr("X");
    add_word(32'd40);
    send_file(1'b1);
    hold_request = 1'b1;
    add_bytes(160);
    send_file(1'b0);
    idle_on = 1'b1;
  endtask

  task automatic test_random_files();
    int base;
    int models;
    int cut;
    base = bytes_sent;
    while (bytes_sent - base < RANDOM_BYTES) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 19) == 0) begin
        add_bytes($urandom_range(1, 24));
        send_file($urandom_range(0, 2) != 0);
      end else begin
        if ($urandom_range(0, 24) == 0) add_bytes(4);
        else add_magic();
        add_word(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 200));
        add_hdr(($urandom_range(0, 19) == 0) ? "P" : "M");
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            models = $urandom_range(0, 3);
            add_hdr("P");
            add_word(($urandom_range(0, 11) == 0) ? 32'hFFFF_FFFE : models);
            repeat (models) add_model(pick_flaw(), 1'b1, vox_count());
          end
          5, 6, 7: begin
            add_hdr("S");
            repeat (3) add_word($urandom);
            add_model(pick_flaw(), 1'b0, vox_count());
          end
          default: begin
            add_hdr("R");
            add_model(pick_flaw(), 1'b1, vox_count());
          end
        endcase
        add_bytes($urandom_range(0, 3));
        if ($urandom_range(0, 9) == 0) begin
          cut = $urandom_range(1, file_q.size());
          while (file_q.size() > cut) void'(file_q.pop_back());
        end
        send_file(1'b1);
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin : receiver
    int pause;
    event_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        event_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 1'b0;
      end
      pause = idle_on ? $urandom_range(0, 3) : 0;
      if (pause > 0) begin
        event_stall <= 1'b1;
        repeat (pause) @(negedge clk);
      end
      event_stall <= 1'b0;
      do @(posedge clk); while (event_valid !== 1'b1);
    end
  end

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : event_check
    event_t want;
    if (!rst && event_valid === 1'b1 && !event_stall) begin
      kind_seen[event_kind]++;
      if (expected_events.size() == 0) begin
        $error("event_kind: expected no event, got %0h", event_kind);
        errors++;
      end else begin
        want = expected_events.pop_front();
        compare_field("event_kind", want.kind, event_kind);
        compare_field("voxel_x", want.voxel_x, voxel_x);
        compare_field("voxel_y", want.voxel_y, voxel_y);
        compare_field("voxel_z", want.voxel_z, voxel_z);
        compare_field("material", want.material, material);
        compare_field("size_x", want.size_x, size_x);
        compare_field("size_y", want.size_y, size_y);
        compare_field("size_z", want.size_z, size_z);
        compare_field("file_version", want.file_version, file_version);
        compare_field("model_number", want.model_number, model_number);
        compare_field("last_voxel", want.last_voxel, last_voxel);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (data_valid && !data_stall) || (event_valid && !event_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("voxel_file_stream_parser_tb failed");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    data_valid = 1'b0;
    data_byte = 8'd0;
    start_of_file = 1'b0;
    clear_parse_state();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_file_header();
    test_chunk_rules();
    test_restart();
    test_back_pressure();
    test_random_files();
    data_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d file bytes; checked %0d voxel, %0d dimension and %0d header events,",
             bytes_sent, kind_seen[EV_VOXEL], kind_seen[EV_DIMENSIONS],
             kind_seen[EV_HEADER_OK]);
    $display("and %0d bad header, %0d size, %0d xyzi and %0d main chunk errors.",
             kind_seen[EV_BAD_HEADER], kind_seen[EV_SIZE_MISSING],
             kind_seen[EV_XYZI_MISSING], kind_seen[EV_MAIN_MISSING]);
    if (errors == 0) begin
      $display("voxel_file_stream_parser_tb passed");
    end else begin
      $display("voxel_file_stream_parser_tb failed");
    end
    $finish;
  end

endmodule
